// ----- rtl/imd_pkg.sv -----
// ----------------------------------------------------------------------------
// imd_pkg: shared types and codes of the message deframer
// Result item layout, result kinds, error codes and register indexes.
// ----------------------------------------------------------------------------
package imd_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  // Error codes
  typedef enum logic [1:0] {
    ERR_MAGIC     = 2'd0,
    ERR_VERSION   = 2'd1,
    ERR_LENGTH    = 2'd2,
    ERR_TRUNCATED = 2'd3
  } err_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAGIC   = 2'd0;
  localparam logic [1:0] CFG_VERSION = 2'd1;
  localparam logic [1:0] CFG_MAX_LEN = 2'd2;

  // Register reset values
  localparam logic [31:0] MAGIC_RST   = 32'd0;
  localparam logic [7:0]  VERSION_RST = 8'd1;
  localparam logic [31:0] MAX_LEN_RST = 32'd65536;

  // Header byte positions of interest
  localparam logic [3:0] POS_MAGIC_END = 4'd3;
  localparam logic [3:0] POS_VERSION   = 4'd4;
  localparam logic [3:0] POS_TYPE      = 4'd5;
  localparam logic [3:0] POS_FLAGS_HI  = 4'd6;
  localparam logic [3:0] POS_FLAGS_LO  = 4'd7;
  localparam logic [3:0] POS_REQ_END   = 4'd11;
  localparam logic [3:0] POS_LEN_END   = 4'd15;

  // Output data width: type, flags, id, length, byte, error, padded to bytes
  localparam int unsigned OUT_DATA_W = 104;

  // One result item as it travels from parser to output stage
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  msg_type;
    logic [15:0] msg_flags;
    logic [31:0] msg_id;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last;
    err_e        error_code;
  } res_t;

endpackage

// ----- rtl/ipc_message_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// ipc_message_deframer_unit: byte-stream IPC message deframer
// Parses a 16-byte big-endian header, checks it, then passes payload bytes.
//
//  Channel   Dir  Handshake            Contents
//  s_axis    in   tvalid/tready        one stream byte, tlast = stream end
//  m_axis    out  tvalid/tready        one result: header, payload byte or error
//  cfg       in   cfg_valid/cfg_ready  register index and 32-bit write data
//
// One input byte per cycle; a byte that gives a result writes it to the queue
// at its accepting edge, and from there it moves into the output register that drives m_axis.
// Input is taken whenever the result queue has room, so a stalled output side
// holds off input only once the queue and output register are full.
// Reset puts the registers at their reset values and the parser at hunting.
// ----------------------------------------------------------------------------
module ipc_message_deframer_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  // input byte stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
  input  logic                           s_axis_tlast,  // stream_end
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] msg_type, [23:8] msg_flags, [55:24] msg_id,
  // [87:56] payload_length, [95:88] payload_byte, [97:96] error_code
  output logic [imd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [1:0]                     m_axis_tuser,  // [1:0] kind
  output logic                           m_axis_tlast   // last
);

  logic          in_fire;
  logic          push;
  imd_pkg::res_t push_res;
  logic          q_full, q_valid, q_pop;
  imd_pkg::res_t q_res;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !q_full;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  imd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_fire_i   (in_fire),
    .in_byte_i   (s_axis_tdata),
    .in_end_i    (s_axis_tlast),
    .push_o      (push),
    .res_o       (push_res)
  );

  imd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_res),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_res)
  );

  imd_emitter u_emitter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_res),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_user_o  (m_axis_tuser),
    .m_last_o  (m_axis_tlast)
  );

endmodule

// ----- rtl/imd_parser.sv -----
// ----------------------------------------------------------------------------
// imd_parser: front part of the deframer
// Accepts stream bytes, tracks the header, checks it and builds result items.
// ----------------------------------------------------------------------------
module imd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration writes
  input  logic             cfg_valid_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i,
  // input bytes
  input  logic             in_fire_i,
  input  logic [7:0]       in_byte_i,
  input  logic             in_end_i,
  // results toward the queue
  output logic             push_o,
  output imd_pkg::res_t    res_o
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'b01,
    PH_PAYLOAD = 2'b10
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  pos_q, pos_d;
  logic [31:0] shift_q, shift_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] flags_q, flags_d;
  logic [31:0] req_q, req_d;
  logic [31:0] len_q, len_d;
  logic [31:0] rem_q, rem_d;

  logic [31:0] magic_q;
  logic [7:0]  version_q;
  logic [31:0] max_len_q;

  logic [31:0] shift_next;
  logic        with_hdr;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= imd_pkg::MAGIC_RST;
      version_q <= imd_pkg::VERSION_RST;
      max_len_q <= imd_pkg::MAX_LEN_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == imd_pkg::CFG_MAGIC)   magic_q   <= cfg_data_i;
      if (cfg_index_i == imd_pkg::CFG_VERSION) version_q <= cfg_data_i[7:0];
      if (cfg_index_i == imd_pkg::CFG_MAX_LEN) max_len_q <= cfg_data_i;
    end
  end

  assign shift_next = {shift_q[23:0], in_byte_i};

  // Per-byte parse step
  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    shift_d  = shift_q;
    type_d   = type_q;
    flags_d  = flags_q;
    req_d    = req_q;
    len_d    = len_q;
    rem_d    = rem_q;
    push_o   = 1'b0;
    with_hdr = 1'b0;
    res_o.kind         = imd_pkg::KIND_ERROR;
    res_o.payload_byte = 8'd0;
    res_o.last         = 1'b0;
    res_o.error_code   = imd_pkg::ERR_MAGIC;

    if (in_fire_i) begin
      if (in_end_i) begin
        // stream closed: truncation if a message was open
        if (phase_q == PH_PAYLOAD || pos_q != 4'd0) begin
          phase_d          = PH_HEADER;
          pos_d            = 4'd0;
          push_o           = 1'b1;
          res_o.error_code = imd_pkg::ERR_TRUNCATED;
        end
      end else if (phase_q == PH_PAYLOAD) begin
        // payload byte, last one closes the message
        rem_d              = rem_q - 32'd1;
        push_o             = 1'b1;
        with_hdr           = 1'b1;
        res_o.kind         = imd_pkg::KIND_PAYLOAD;
        res_o.payload_byte = in_byte_i;
        if (rem_q == 32'd1) begin
          phase_d    = PH_HEADER;
          pos_d      = 4'd0;
          res_o.last = 1'b1;
        end
      end else begin
        // header byte
        shift_d = shift_next;
        pos_d   = pos_q + 4'd1;
        unique case (pos_q)
          imd_pkg::POS_MAGIC_END: begin
            if (shift_next != magic_q) begin
              pos_d  = 4'd0;
              push_o = 1'b1;
              res_o.error_code = imd_pkg::ERR_MAGIC;
            end
          end
          imd_pkg::POS_VERSION: begin
            if (in_byte_i != version_q) begin
              pos_d  = 4'd0;
              push_o = 1'b1;
              res_o.error_code = imd_pkg::ERR_VERSION;
            end
          end
          imd_pkg::POS_TYPE: type_d = in_byte_i;
          imd_pkg::POS_FLAGS_HI,
          imd_pkg::POS_FLAGS_LO: flags_d = {flags_q[7:0], in_byte_i};
          imd_pkg::POS_REQ_END: req_d = shift_next;
          imd_pkg::POS_LEN_END: begin
            len_d  = shift_next;
            pos_d  = 4'd0;
            push_o = 1'b1;
            if (shift_next > max_len_q) begin
              res_o.error_code = imd_pkg::ERR_LENGTH;
            end else begin
              with_hdr   = 1'b1;
              res_o.kind = imd_pkg::KIND_HEADER;
              if (shift_next == 32'd0) begin
                res_o.last = 1'b1;
              end else begin
                phase_d = PH_PAYLOAD;
                rem_d   = shift_next;
              end
            end
          end
          default: ;
        endcase
      end
    end

    // header fields only ride on header and payload results
    res_o.msg_type       = with_hdr ? type_d  : 8'd0;
    res_o.msg_flags      = with_hdr ? flags_d : 16'd0;
    res_o.msg_id         = with_hdr ? req_d   : 32'd0;
    res_o.payload_length = with_hdr ? len_d   : 32'd0;
    if (with_hdr) res_o.error_code = imd_pkg::ERR_MAGIC;
  end

  // Parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pos_q   <= 4'd0;
      shift_q <= 32'd0;
      type_q  <= 8'd0;
      flags_q <= 16'd0;
      req_q   <= 32'd0;
      len_q   <= 32'd0;
      rem_q   <= 32'd0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      shift_q <= shift_d;
      type_q  <= type_d;
      flags_q <= flags_d;
      req_q   <= req_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
    end
  end

endmodule

// ----- rtl/imd_queue.sv -----
// ----------------------------------------------------------------------------
// imd_queue: short result queue between parser and output stage
// Register-based FIFO of result items; either side may stall on its own.
// ----------------------------------------------------------------------------
module imd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  imd_pkg::res_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output imd_pkg::res_t data_o
);

  localparam int unsigned PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  imd_pkg::res_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop)      cnt_q <= cnt_q + CNT_W'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

endmodule

// ----- rtl/imd_emitter.sv -----
// ----------------------------------------------------------------------------
// imd_emitter: back part of the deframer
// Takes result items from the queue into an output register and packs them.
// ----------------------------------------------------------------------------
module imd_emitter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  imd_pkg::res_t                   q_data_i,
  output logic                            q_pop_o,
  output logic                            m_valid_o,
  input  logic                            m_ready_i,
  output logic [imd_pkg::OUT_DATA_W-1:0]  m_data_o,
  output logic [1:0]                      m_user_o,
  output logic                            m_last_o
);

  logic          out_valid_q;
  imd_pkg::res_t out_q;
  logic          load;

  // Refill when empty or when the held result is being taken
  assign load    = q_valid_i && (!out_valid_q || m_ready_i);
  assign q_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= q_data_i;
  end

  // Pack fields, lowest first
  assign m_valid_o = out_valid_q;
  assign m_data_o  = {6'd0, out_q.error_code, out_q.payload_byte, out_q.payload_length,
                      out_q.msg_id, out_q.msg_flags, out_q.msg_type};
  assign m_user_o  = out_q.kind;
  assign m_last_o  = out_q.last;

endmodule
